// File: rtl/core/segment_segment_squared_distance_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment distance block
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SEGMENT_SQUARED_DISTANCE_TOP_MACROS_SVH
`define SEGMENT_SEGMENT_SQUARED_DISTANCE_TOP_MACROS_SVH

// Check an implication on every clock edge outside reset
`define SSD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a next-cycle implication outside reset
`define SSD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// Segment distance package
// Beat types and fixed widths for the segment distance block.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int unsigned IN_BITS  = 12;
   localparam int unsigned NUM_BITS = 50;
   localparam int unsigned DEN_BITS = 25;

   typedef struct packed {
      logic signed [IN_BITS-1:0] a_start_x;
      logic signed [IN_BITS-1:0] a_start_y;
      logic signed [IN_BITS-1:0] a_end_x;
      logic signed [IN_BITS-1:0] a_end_y;
      logic signed [IN_BITS-1:0] b_start_x;
      logic signed [IN_BITS-1:0] b_start_y;
      logic signed [IN_BITS-1:0] b_end_x;
      logic signed [IN_BITS-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic [NUM_BITS-1:0] dist_num;
      logic [DEN_BITS-1:0] dist_den;
   } rsp_type;

   // Rational candidate: num is up to 50 bits, den up to 25 bits
   typedef struct packed {
      logic [NUM_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
   } rat_type;

   // Point-to-segment task selected by the front part
   typedef struct packed {
      logic signed [13:0] px;
      logic signed [13:0] py;
      logic signed [13:0] sx;
      logic signed [13:0] sy;
      logic signed [13:0] tx;
      logic signed [13:0] ty;
   } ps_job_type;

   // Result kind decided by the front part
   typedef enum logic [3:0] {
      KIND_ZERO = 4'b0001,  // crossing or touching
      KIND_ONE  = 4'b0010,  // single point-to-segment
      KIND_TWO  = 4'b0100,  // two candidates, take the smaller
      KIND_PAR  = 4'b1000   // parallel or collinear handling
   } kind_type;

endpackage

// File: rtl/core/segment_segment_squared_distance_top.sv
// Throughput: one beat per cycle while the job queue has space; the front
// pipe never stalls, and the back pipe stalls only when the result queue is full.
// Reset: synchronous, active high; clears valid flags and queue pointers.
// ----------------------------------------------------------------------------
// Segment-segment squared distance
// Exact squared distance of two 2D segments as an unreduced fraction.
// ----------------------------------------------------------------------------
`include "segment_segment_squared_distance_top_macros.svh"
module segment_segment_squared_distance_top #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ssd_pkg::req_type  req_beat,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output ssd_pkg::rsp_type  rsp_beat
);

   localparam int unsigned JOB_W = 4 + 3 * $bits(ssd_pkg::ps_job_type) + 1;
   localparam int unsigned RSP_W = $bits(ssd_pkg::rsp_type);

   logic                f_valid, f_line;
   ssd_pkg::kind_type   f_kind;
   ssd_pkg::ps_job_type f_j1, f_j2, f_pp;
   logic                jq_full, jq_empty, b_valid, b_stall;
   logic [JOB_W-1:0]    jq_rd;
   ssd_pkg::rsp_type    b_beat;
   logic                rq_full;
   logic [RSP_W-1:0]    rq_rd;
   // Back pipe output seen at the previous edge
   logic [2:0]          inflight_ff;

   assign full = jq_full;

   ssd_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .in_valid(push && !jq_full), .in_beat(req_beat),
      .stall(1'b0), .out_valid(f_valid), .out_kind(f_kind), .out_job1(f_j1),
      .out_job2(f_j2), .out_par_pp(f_pp), .out_par_line(f_line)
   );

   // Job queue sized for the front pipe; accept only with space for it
   logic jq_cnt_full;
   ssd_queue #(.W(JOB_W)) u_jq (
      .clock, .reset, .push(f_valid), .wdata({f_kind, f_j1, f_j2, f_pp, f_line}),
      .full(jq_cnt_full), .pop(!b_stall && !jq_empty), .rdata(jq_rd), .empty(jq_empty)
   );

   // Hold input while the queue plus the front beat in flight would overflow
   logic front_busy_ff;
   always_ff @(posedge clock) begin
      if (reset) front_busy_ff <= 1'b0;
      else front_busy_ff <= push && !jq_full;
   end
   assign jq_full = jq_cnt_full || (front_busy_ff && !jq_empty && b_stall);

   ssd_back u_back (
      .clock, .reset, .in_valid(!jq_empty),
      .in_kind(ssd_pkg::kind_type'(jq_rd[JOB_W-1 -: 4])),
      .in_job1(jq_rd[JOB_W-5 -: 84]), .in_job2(jq_rd[JOB_W-89 -: 84]),
      .in_par_pp(jq_rd[JOB_W-173 -: 84]), .in_par_line(jq_rd[0]),
      .stall(b_stall), .out_valid(b_valid), .out_beat(b_beat)
   );

   // Stall back when the result queue cannot take its output beat
   assign b_stall = b_valid && rq_full;

   ssd_queue #(.W(RSP_W)) u_rq (
      .clock, .reset, .push(b_valid && !b_stall), .wdata(b_beat), .full(rq_full),
      .pop(pop), .rdata(rq_rd), .empty(empty)
   );
   assign rsp_beat = ssd_pkg::rsp_type'(rq_rd);

   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= 3'd0;
      else inflight_ff <= {2'b0, b_valid};
   end

   `SSD_ASSERT_IMP(a_rsp_den, clock, reset, !empty, rsp_beat.dist_den != 0, "zero denominator")
   `SSD_ASSERT_IMP(a_stall_full, clock, reset, b_stall, rq_full, "stall without full queue")
   `SSD_ASSERT_NXT(a_infl, clock, reset, b_valid, inflight_ff == 3'd1, "in-flight flag lost")

endmodule

// File: rtl/core/ssd_front.sv
// ----------------------------------------------------------------------------
// Segment distance front part
// Sign-extends endpoints, works out the orientation cross products in a
// registered stage and classifies each pair into a job for the back part.
// ----------------------------------------------------------------------------
module ssd_front #(
   parameter int unsigned COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  ssd_pkg::req_type       in_beat,
   input  logic                   stall,
   output logic                   out_valid,
   output ssd_pkg::kind_type      out_kind,
   output ssd_pkg::ps_job_type    out_job1,
   output ssd_pkg::ps_job_type    out_job2,
   output ssd_pkg::ps_job_type    out_par_pp,
   output logic                   out_par_line
);

   typedef logic signed [13:0] crd_type;
   typedef logic signed [28:0] crs_type;

   // Sign-extend from bit COORD_BITS-1 of a field
   function automatic crd_type sx(input logic [ssd_pkg::IN_BITS-1:0] v);
      logic [ssd_pkg::IN_BITS-1:0] t;
      t = v << (ssd_pkg::IN_BITS - COORD_BITS);
      return crd_type'($signed(t) >>> (ssd_pkg::IN_BITS - COORD_BITS));
   endfunction

   function automatic crs_type orient(input crd_type px, input crd_type py,
                                      input crd_type qx, input crd_type qy,
                                      input crd_type rx, input crd_type ry);
      crd_type ux, uy, vx, vy;
      ux = qx - px; uy = qy - py; vx = rx - px; vy = ry - py;
      return crs_type'(ux * vy) - crs_type'(uy * vx);
   endfunction

   function automatic crs_type dotp(input crd_type ax, input crd_type ay,
                                    input crd_type bx, input crd_type by);
      return crs_type'(ax * bx) + crs_type'(ay * by);
   endfunction

   // Stage one registers: coordinates plus cross products
   logic    s1_valid_ff, s1_valid_in;
   crd_type p_ff [8];
   crd_type p_in [8];
   crs_type c1s_ff, c1e_ff, c2s_ff, c2e_ff;
   crs_type c1s_in, c1e_in, c2s_in, c2e_in;
   // Parallel-case angle tests, also registered
   logic    ac_ff [4];
   logic    ac_in [4];
   logic    same_ff, same_in;

   always_comb begin
      p_in[0] = sx(in_beat.a_start_x); p_in[1] = sx(in_beat.a_start_y);
      p_in[2] = sx(in_beat.a_end_x);   p_in[3] = sx(in_beat.a_end_y);
      p_in[4] = sx(in_beat.b_start_x); p_in[5] = sx(in_beat.b_start_y);
      p_in[6] = sx(in_beat.b_end_x);   p_in[7] = sx(in_beat.b_end_y);
      c1s_in = orient(p_in[4], p_in[5], p_in[6], p_in[7], p_in[0], p_in[1]);
      c1e_in = orient(p_in[4], p_in[5], p_in[6], p_in[7], p_in[2], p_in[3]);
      c2s_in = orient(p_in[0], p_in[1], p_in[2], p_in[3], p_in[4], p_in[5]);
      c2e_in = orient(p_in[0], p_in[1], p_in[2], p_in[3], p_in[6], p_in[7]);
      // acute(s1,t1,s2), acute(t1,s1,t2), acute(s1,t1,t2), acute(t1,s1,s2)
      ac_in[0] = dotp(p_in[0] - p_in[2], p_in[1] - p_in[3],
                      p_in[4] - p_in[2], p_in[5] - p_in[3]) > 0;
      ac_in[1] = dotp(p_in[2] - p_in[0], p_in[3] - p_in[1],
                      p_in[6] - p_in[0], p_in[7] - p_in[1]) > 0;
      ac_in[2] = dotp(p_in[0] - p_in[2], p_in[1] - p_in[3],
                      p_in[6] - p_in[2], p_in[7] - p_in[3]) > 0;
      ac_in[3] = dotp(p_in[2] - p_in[0], p_in[3] - p_in[1],
                      p_in[4] - p_in[0], p_in[5] - p_in[1]) > 0;
      same_in = 1'b0;
      begin
         crd_type d1x, d1y, d2x, d2y, a1x, a1y;
         d1x = p_in[2] - p_in[0]; d1y = p_in[3] - p_in[1];
         d2x = p_in[6] - p_in[4]; d2y = p_in[7] - p_in[5];
         a1x = d1x < 0 ? -d1x : d1x;
         a1y = d1y < 0 ? -d1y : d1y;
         if (a1x > a1y) begin
            same_in = ((d1x > 0) == (d2x > 0)) && ((d1x < 0) == (d2x < 0));
         end else begin
            same_in = ((d1y > 0) == (d2y > 0)) && ((d1y < 0) == (d2y < 0));
         end
      end
      s1_valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         p_ff <= p_in; c1s_ff <= c1s_in; c1e_ff <= c1e_in;
         c2s_ff <= c2s_in; c2e_ff <= c2e_in; ac_ff <= ac_in; same_ff <= same_in;
      end
   end

   // Build a point-to-segment job from three points
   function automatic ssd_pkg::ps_job_type mkjob(input crd_type px, input crd_type py,
                                                 input crd_type sxv, input crd_type syv,
                                                 input crd_type tx, input crd_type ty);
      ssd_pkg::ps_job_type j;
      j.px = px; j.py = py; j.sx = sxv; j.sy = syv; j.tx = tx; j.ty = ty;
      return j;
   endfunction

   // cross_test: 1 crossing, 0 apart, 2 both zero
   function automatic logic [1:0] ctest(input crs_type cs, input crs_type ce);
      if (cs < 0) return {1'b0, ce >= 0};
      if (ce <= 0) begin
         if (cs == 0 && ce == 0) return 2'd2;
         return 2'd1;
      end
      return {1'b0, cs == 0};
   endfunction

   // Classify the registered pair
   always_comb begin
      logic [1:0] k1, k2;
      logic deg_a, deg_b, par;
      crs_type a1s, a1e, a2s, a2e;
      logic signed [29:0] dm1, dm2;
      k1 = ctest(c1s_ff, c1e_ff);
      k2 = ctest(c2s_ff, c2e_ff);
      deg_a = (p_ff[0] == p_ff[2]) && (p_ff[1] == p_ff[3]);
      deg_b = (p_ff[4] == p_ff[6]) && (p_ff[5] == p_ff[7]);
      a1s = c1s_ff < 0 ? -c1s_ff : c1s_ff;
      a1e = c1e_ff < 0 ? -c1e_ff : c1e_ff;
      a2s = c2s_ff < 0 ? -c2s_ff : c2s_ff;
      a2e = c2e_ff < 0 ? -c2e_ff : c2e_ff;
      dm1 = 30'(a1s) - 30'(a1e);
      dm2 = 30'(a2s) - 30'(a2e);
      out_kind = ssd_pkg::KIND_PAR;
      out_job1 = mkjob(p_ff[0], p_ff[1], p_ff[4], p_ff[5], p_ff[6], p_ff[7]);
      out_job2 = mkjob(p_ff[4], p_ff[5], p_ff[0], p_ff[1], p_ff[2], p_ff[3]);
      par = 1'b0;
      priority if (deg_a) begin
         out_kind = ssd_pkg::KIND_ONE;
      end else if (deg_b) begin
         out_kind = ssd_pkg::KIND_ONE;
         out_job1 = out_job2;
      end else if (k1 == 2'd2 || k2 == 2'd2) begin
         par = 1'b1;
      end else if (k1[0] && k2[0]) begin
         out_kind = ssd_pkg::KIND_ZERO;
      end else if (k1[0]) begin
         if (dm2 == 0) par = 1'b1;
         else begin
            out_kind = ssd_pkg::KIND_ONE;
            out_job1 = dm2 < 0 ? out_job2
                     : mkjob(p_ff[6], p_ff[7], p_ff[0], p_ff[1], p_ff[2], p_ff[3]);
         end
      end else if (k2[0]) begin
         if (dm1 == 0) par = 1'b1;
         else begin
            out_kind = ssd_pkg::KIND_ONE;
            if (dm1 > 0)
               out_job1 = mkjob(p_ff[2], p_ff[3], p_ff[4], p_ff[5], p_ff[6], p_ff[7]);
         end
      end else if (dm1 == 0 || dm2 == 0) begin
         par = 1'b1;
      end else begin
         out_kind = ssd_pkg::KIND_TWO;
         if (dm1 > 0)
            out_job1 = mkjob(p_ff[2], p_ff[3], p_ff[4], p_ff[5], p_ff[6], p_ff[7]);
         if (dm2 > 0)
            out_job2 = mkjob(p_ff[6], p_ff[7], p_ff[0], p_ff[1], p_ff[2], p_ff[3]);
      end
      // Parallel handling: an endpoint pair or B start against A's line
      out_par_line = 1'b0;
      out_par_pp = mkjob(p_ff[4], p_ff[5], p_ff[0], p_ff[1], p_ff[2], p_ff[3]);
      if (par) out_kind = ssd_pkg::KIND_PAR;
      if (same_ff) begin
         if (!ac_ff[0])      out_par_pp = mkjob(p_ff[2], p_ff[3], p_ff[4], p_ff[5], 14'sd0, 14'sd0);
         else if (!ac_ff[1]) out_par_pp = mkjob(p_ff[0], p_ff[1], p_ff[6], p_ff[7], 14'sd0, 14'sd0);
         else                out_par_line = 1'b1;
      end else begin
         if (!ac_ff[2])      out_par_pp = mkjob(p_ff[2], p_ff[3], p_ff[6], p_ff[7], 14'sd0, 14'sd0);
         else if (!ac_ff[3]) out_par_pp = mkjob(p_ff[0], p_ff[1], p_ff[4], p_ff[5], 14'sd0, 14'sd0);
         else                out_par_line = 1'b1;
      end
      out_valid = s1_valid_ff;
   end

endmodule

// File: rtl/core/ssd_queue.sv
// ----------------------------------------------------------------------------
// Segment distance queue
// Two-entry queue, used for jobs between the front and back parts and for results.
// ----------------------------------------------------------------------------
module ssd_queue #(
   parameter int unsigned W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty
);

   logic [W-1:0] mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rp_ff];

   // Advance pointers and count
   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= wdata;
   end

endmodule

// File: rtl/core/ssd_back.sv
// ----------------------------------------------------------------------------
// Segment distance back part
// Runs the point-to-segment jobs, picks the smaller rational and delivers
// the result through a four-stage pipeline with a stall on every stage.
// ----------------------------------------------------------------------------
module ssd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ssd_pkg::kind_type   in_kind,
   input  ssd_pkg::ps_job_type in_job1,
   input  ssd_pkg::ps_job_type in_job2,
   input  ssd_pkg::ps_job_type in_par_pp,
   input  logic                in_par_line,
   input  logic                stall,
   output logic                out_valid,
   output ssd_pkg::rsp_type    out_beat
);

   typedef logic signed [13:0] crd_type;
   typedef logic signed [29:0] wide_type;

   // Per-job stage-one products
   typedef struct packed {
      logic              pt_s;   // d <= 0
      logic              pt_t;   // d > |v|^2
      logic [28:0]       ds;     // |p-s|^2
      logic [28:0]       dt;     // |p-t|^2
      logic signed [28:0] cr;    // cross(v, p-s)
      logic [28:0]       vv;     // |v|^2
   } ps_type;

   function automatic ps_type ps_first(input ssd_pkg::ps_job_type j);
      ps_type r;
      crd_type dx, dy, vx, vy, ex, ey;
      wide_type d, vv;
      dx = j.px - j.sx; dy = j.py - j.sy;
      vx = j.tx - j.sx; vy = j.ty - j.sy;
      ex = j.px - j.tx; ey = j.py - j.ty;
      d  = wide_type'(dx * vx) + wide_type'(dy * vy);
      vv = wide_type'(vx * vx) + wide_type'(vy * vy);
      r.pt_s = d <= 0;
      r.pt_t = d > vv;
      r.ds = 29'(wide_type'(dx * dx) + wide_type'(dy * dy));
      r.dt = 29'(wide_type'(ex * ex) + wide_type'(ey * ey));
      r.cr = 29'(wide_type'(vx * dy) - wide_type'(vy * dx));
      r.vv = 29'(vv);
      return r;
   endfunction

   // Stage one: products
   logic               v1_ff;
   ssd_pkg::kind_type  k1_ff;
   ps_type             a1_ff, b1_ff, q1_ff;
   logic               pl1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (!stall) v1_ff <= in_valid;
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         k1_ff <= in_kind; a1_ff <= ps_first(in_job1);
         b1_ff <= ps_first(in_job2); q1_ff <= ps_first(in_par_pp);
         pl1_ff <= in_par_line;
      end
   end

   // Reduce one job to a rational (an endpoint distance, or the square of the cross product over |v|^2)
   function automatic ssd_pkg::rat_type ps_rat(input ps_type p);
      ssd_pkg::rat_type r;
      logic [27:0] ac;
      ac = 28'(p.cr < 0 ? -p.cr : p.cr);
      if (p.pt_s) begin
         r.num = 50'(p.ds); r.den = 25'd1;
      end else if (p.pt_t) begin
         r.num = 50'(p.dt); r.den = 25'd1;
      end else begin
         r.num = 50'(ac) * 50'(ac); r.den = 25'(p.vv);
      end
      return r;
   endfunction

   // Stage two: candidate rationals
   logic              v2_ff;
   ssd_pkg::kind_type k2_ff;
   ssd_pkg::rat_type  m1_ff, m2_ff, par_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (!stall) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      ssd_pkg::rat_type pr;
      if (!stall) begin
         k2_ff <= k1_ff;
         m1_ff <= ps_rat(a1_ff);
         m2_ff <= ps_rat(b1_ff);
         // Line case: B start against A's line; else point pair distance
         pr.num = pl1_ff ? 50'(q1_ff.cr < 0 ? -q1_ff.cr : q1_ff.cr)
                         * 50'(q1_ff.cr < 0 ? -q1_ff.cr : q1_ff.cr)
                         : 50'(q1_ff.ds);
         pr.den = pl1_ff ? 25'(q1_ff.vv) : 25'd1;
         par_ff <= pr;
      end
   end

   // Stage three: partial cross products, numerator split into two halves
   logic              v3_ff;
   ssd_pkg::kind_type k3_ff;
   ssd_pkg::rat_type  m1_3_ff, m2_3_ff, par3_ff;
   logic [49:0]       x1h_ff, x1l_ff, x2h_ff, x2l_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (!stall) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         k3_ff <= k2_ff; m1_3_ff <= m1_ff; m2_3_ff <= m2_ff; par3_ff <= par_ff;
         x1h_ff <= 50'(m1_ff.num[49:25]) * 50'(m2_ff.den);
         x1l_ff <= 50'(m1_ff.num[24:0]) * 50'(m2_ff.den);
         x2h_ff <= 50'(m2_ff.num[49:25]) * 50'(m1_ff.den);
         x2l_ff <= 50'(m2_ff.num[24:0]) * 50'(m1_ff.den);
      end
   end

   // Stage four: combine the halves into full cross products
   logic              v4_ff;
   ssd_pkg::kind_type k4_ff;
   ssd_pkg::rat_type  m1_4_ff, m2_4_ff, par4_ff;
   logic [74:0]       x1_ff, x2_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (!stall) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         k4_ff <= k3_ff; m1_4_ff <= m1_3_ff; m2_4_ff <= m2_3_ff; par4_ff <= par3_ff;
         x1_ff <= (75'(x1h_ff) << 25) + 75'(x1l_ff);
         x2_ff <= (75'(x2h_ff) << 25) + 75'(x2l_ff);
      end
   end

   // Select the result
   always_comb begin
      out_valid = v4_ff;
      unique case (k4_ff)
         ssd_pkg::KIND_ZERO: begin
            out_beat.dist_num = '0; out_beat.dist_den = 25'd1;
         end
         ssd_pkg::KIND_ONE: begin
            out_beat.dist_num = m1_4_ff.num; out_beat.dist_den = m1_4_ff.den;
         end
         ssd_pkg::KIND_TWO: begin
            if (x1_ff < x2_ff) begin
               out_beat.dist_num = m1_4_ff.num; out_beat.dist_den = m1_4_ff.den;
            end else begin
               out_beat.dist_num = m2_4_ff.num; out_beat.dist_den = m2_4_ff.den;
            end
         end
         default: begin
            out_beat.dist_num = par4_ff.num; out_beat.dist_den = par4_ff.den;
         end
      endcase
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment distance testbench
// Drives segment pairs into the distance block through its queue ports,
// predicts each exact squared distance and checks every result beat in order.
// ----------------------------------------------------------------------------

// Scoreboard: predicts distances for accepted beats and checks result beats
class dist_scoreboard;
   ssd_pkg::rsp_type pending_dist[$];
   int errors;

   typedef struct {
      longint x;
      longint y;
   } pnt_type;

   typedef struct {
      longint num;
      longint den;
   } frac_type;

   function new();
      errors = 0;
   endfunction

   function longint widen(logic [11:0] v);
      longint r;
      r = longint'($signed(v));
      return r;
   endfunction

   function pnt_type minus(pnt_type a, pnt_type b);
      pnt_type r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      return r;
   endfunction

   function longint dotp(pnt_type a, pnt_type b);
      return a.x * b.x + a.y * b.y;
   endfunction

   function longint crossp(pnt_type a, pnt_type b);
      return a.x * b.y - a.y * b.x;
   endfunction

   function longint absv(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function int signv(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function frac_type frac(longint n, longint d);
      frac_type r;
      r.num = n;
      r.den = d;
      return r;
   endfunction

   function frac_type point_point(pnt_type a, pnt_type b);
      pnt_type d;
      d = minus(a, b);
      return frac(dotp(d, d), 1);
   endfunction

   function bit is_acute(pnt_type p, pnt_type q, pnt_type r);
      return dotp(minus(p, q), minus(r, q)) > 0;
   endfunction

   function longint turn(pnt_type p, pnt_type q, pnt_type r);
      return crossp(minus(q, p), minus(r, p));
   endfunction

   function frac_type point_line(pnt_type p, pnt_type s, pnt_type t);
      pnt_type v;
      longint c;
      v = minus(t, s);
      c = crossp(v, minus(p, s));
      return frac(c * c, dotp(v, v));
   endfunction

   function frac_type point_seg(pnt_type p, pnt_type s, pnt_type t);
      pnt_type dv;
      pnt_type v;
      longint d;
      dv = minus(p, s);
      v = minus(t, s);
      d = dotp(dv, v);
      if (d <= 0) return frac(dotp(dv, dv), 1);
      if (d > dotp(v, v)) return point_point(p, t);
      return point_line(p, s, t);
   endfunction

   function frac_type parallel_dist(pnt_type s1, pnt_type t1, pnt_type s2, pnt_type t2);
      pnt_type d1;
      pnt_type d2;
      bit same;
      d1 = minus(t1, s1);
      d2 = minus(t2, s2);
      if (absv(d1.x) > absv(d1.y)) same = signv(d1.x) == signv(d2.x);
      else same = signv(d1.y) == signv(d2.y);
      if (same) begin
         if (!is_acute(s1, t1, s2)) return point_point(t1, s2);
         if (!is_acute(t1, s1, t2)) return point_point(s1, t2);
      end else begin
         if (!is_acute(s1, t1, t2)) return point_point(t1, t2);
         if (!is_acute(t1, s1, s2)) return point_point(s1, s2);
      end
      return point_line(s2, s1, t1);
   endfunction

   // 1 crossing, 0 apart, -1 both ends on the line
   function int straddle(longint cs, longint ce);
      if (cs < 0) return (ce >= 0) ? 1 : 0;
      if (ce <= 0) begin
         if (cs == 0 && ce == 0) return -1;
         return 1;
      end
      return (cs == 0) ? 1 : 0;
   endfunction

   function frac_type seg_dist(pnt_type s1, pnt_type t1, pnt_type s2, pnt_type t2);
      longint c1s, c1e, c2s, c2e, dm;
      int k1, k2;
      frac_type m1, m2;
      logic [127:0] lhs, rhs;
      if (s1.x == t1.x && s1.y == t1.y) return point_seg(s1, s2, t2);
      if (s2.x == t2.x && s2.y == t2.y) return point_seg(s2, s1, t1);
      c1s = turn(s2, t2, s1);
      c1e = turn(s2, t2, t1);
      c2s = turn(s1, t1, s2);
      c2e = turn(s1, t1, t2);
      k1 = straddle(c1s, c1e);
      if (k1 < 0) return parallel_dist(s1, t1, s2, t2);
      k2 = straddle(c2s, c2e);
      if (k2 < 0) return parallel_dist(s1, t1, s2, t2);
      if (k1 != 0 && k2 != 0) return frac(0, 1);
      if (k1 != 0) begin
         dm = absv(c2s) - absv(c2e);
         if (dm < 0) return point_seg(s2, s1, t1);
         if (dm > 0) return point_seg(t2, s1, t1);
         return parallel_dist(s1, t1, s2, t2);
      end
      if (k2 != 0) begin
         dm = absv(c1s) - absv(c1e);
         if (dm < 0) return point_seg(s1, s2, t2);
         if (dm > 0) return point_seg(t1, s2, t2);
         return parallel_dist(s1, t1, s2, t2);
      end
      dm = absv(c1s) - absv(c1e);
      if (dm == 0) return parallel_dist(s1, t1, s2, t2);
      m1 = (dm < 0) ? point_seg(s1, s2, t2) : point_seg(t1, s2, t2);
      dm = absv(c2s) - absv(c2e);
      if (dm == 0) return parallel_dist(s1, t1, s2, t2);
      m2 = (dm < 0) ? point_seg(s2, s1, t1) : point_seg(t2, s1, t1);
      // compare cross-multiplied without overflow
      lhs = 128'(m1.num) * 128'(m2.den);
      rhs = 128'(m2.num) * 128'(m1.den);
      return (lhs < rhs) ? m1 : m2;
   endfunction

   // Note an accepted input beat and queue its expected distance
   function void note_segments(ssd_pkg::req_type b);
      pnt_type s1, t1, s2, t2;
      frac_type r;
      ssd_pkg::rsp_type e;
      s1.x = widen(b.a_start_x); s1.y = widen(b.a_start_y);
      t1.x = widen(b.a_end_x);   t1.y = widen(b.a_end_y);
      s2.x = widen(b.b_start_x); s2.y = widen(b.b_start_y);
      t2.x = widen(b.b_end_x);   t2.y = widen(b.b_end_y);
      r = seg_dist(s1, t1, s2, t2);
      e.dist_num = r.num[ssd_pkg::NUM_BITS-1:0];
      e.dist_den = r.den[ssd_pkg::DEN_BITS-1:0];
      pending_dist.push_back(e);
   endfunction

   // Check a result beat against the oldest expected distance
   function void check_distance(ssd_pkg::rsp_type got);
      ssd_pkg::rsp_type e;
      if (pending_dist.size() == 0) begin
         report_mismatch($sformatf("unexpected result num=%0d den=%0d",
                                   got.dist_num, got.dist_den));
         return;
      end
      e = pending_dist.pop_front();
      if (got.dist_num !== e.dist_num)
         report_mismatch($sformatf("dist_num got %0d want %0d",
                                   got.dist_num, e.dist_num));
      if (got.dist_den !== e.dist_den)
         report_mismatch($sformatf("dist_den got %0d want %0d",
                                   got.dist_den, e.dist_den));
   endfunction

   function void report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endfunction
endclass

module tb_top;

   logic             clock;
   logic             reset;
   logic             push;
   ssd_pkg::req_type req_beat;
   logic             full;
   logic             empty;
   logic             pop;
   ssd_pkg::rsp_type rsp_beat;

   dist_scoreboard board;
   int send_idle_pct;
   int recv_idle_pct;
   bit hold_off;
   bit sending_done;

   segment_segment_squared_distance_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_beat (req_beat),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_beat (rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // Offer one beat and hold it until accepted
   task automatic send_segments(ssd_pkg::req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_beat <= b;
      do @(posedge clock); while (full);
      board.note_segments(b);
   endtask

   function automatic logic [11:0] rand_coord(int mode);
      case (mode)
         0: return 12'($urandom_range(4095));
         1: return 12'($signed($urandom_range(16)) - 8);
         2: return $urandom_range(1) ? 12'h800 : 12'h7FF;
         default: return 12'($signed($urandom_range(200)) - 100);
      endcase
   endfunction

   function automatic ssd_pkg::req_type rand_pair();
      ssd_pkg::req_type b;
      int m;
      int sh;
      logic signed [11:0] dx, dy, ox, oy;
      m = $urandom_range(9);
      b = '0;
      b.a_start_x = rand_coord(m % 4); b.a_start_y = rand_coord(m % 4);
      b.a_end_x   = rand_coord(m % 4); b.a_end_y   = rand_coord(m % 4);
      b.b_start_x = rand_coord(m % 4); b.b_start_y = rand_coord(m % 4);
      b.b_end_x   = rand_coord(m % 4); b.b_end_y   = rand_coord(m % 4);
      if (m == 4) begin
         // degenerate one or both segments
         if ($urandom_range(1)) {b.a_end_x, b.a_end_y} = {b.a_start_x, b.a_start_y};
         if ($urandom_range(1)) {b.b_end_x, b.b_end_y} = {b.b_start_x, b.b_start_y};
      end else if (m >= 5 && m <= 7) begin
         // parallel or collinear pair along a small direction
         dx = 12'($signed($urandom_range(10)) - 5);
         dy = 12'($signed($urandom_range(10)) - 5);
         sh = $signed($urandom_range(8)) - 4;
         ox = (m == 5) ? 12'sd0 : 12'($signed($urandom_range(20)) - 10);
         oy = (m == 5) ? 12'sd0 : 12'($signed($urandom_range(20)) - 10);
         b.a_start_x = 12'($signed($urandom_range(40)) - 20);
         b.a_start_y = 12'($signed($urandom_range(40)) - 20);
         b.a_end_x   = b.a_start_x + dx * 12'($urandom_range(1, 3));
         b.a_end_y   = b.a_start_y + dy * 12'($urandom_range(1, 3));
         b.b_start_x = b.a_start_x + ox + dx * 12'(sh);
         b.b_start_y = b.a_start_y + oy + dy * 12'(sh);
         b.b_end_x   = b.b_start_x + dx * 12'($signed($urandom_range(6)) - 3);
         b.b_end_y   = b.b_start_y + dy * 12'($signed($urandom_range(6)) - 3);
      end
      return b;
   endfunction

   function automatic ssd_pkg::req_type make_pair(int ax, int ay, int bx, int by,
                                                  int cx, int cy, int dx, int dy);
      ssd_pkg::req_type b;
      b.a_start_x = 12'(ax); b.a_start_y = 12'(ay);
      b.a_end_x   = 12'(bx); b.a_end_y   = 12'(by);
      b.b_start_x = 12'(cx); b.b_start_y = 12'(cy);
      b.b_end_x   = 12'(dx); b.b_end_y   = 12'(dy);
      return b;
   endfunction

   // Drain result beats, idling at random and holding off on request
   initial begin
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            pop <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(99) < recv_idle_pct) begin
            pop <= 1'b0;
            @(posedge clock);
         end else begin
            pop <= 1'b1;
            @(posedge clock);
            if (!empty) board.check_distance(rsp_beat);
         end
      end
   end

   // Long stall on the result side while the sender keeps going
   initial begin
      hold_off = 1'b0;
      @(posedge clock);
      while (sending_done || board.pending_dist.size() <= 2) @(posedge clock);
      hold_off = 1'b1;
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      board = new();
      sending_done = 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 59;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_beat <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, degenerate, crossing, collinear, parallel, ties
      send_segments(make_pair(-2048, -2048, 2047, 2047, -2048, 2047, 2047, -2048));
      send_segments(make_pair(-2048, -2048, -2048, -2048, 2047, 2047, 2047, 2047));
      send_segments(make_pair(0, 0, 0, 0, -5, 3, 5, 3));
      send_segments(make_pair(-5, 3, 5, 3, 8, 1, 8, 1));
      send_segments(make_pair(-2048, 0, 2047, 0, 0, 1, 0, 2047));
      send_segments(make_pair(0, 0, 4, 0, 6, 0, 9, 0));
      send_segments(make_pair(0, 0, 4, 0, 9, 0, 6, 0));
      send_segments(make_pair(0, 0, 4, 0, 2, 0, 7, 0));
      send_segments(make_pair(0, 0, 4, 0, -3, 0, -1, 0));
      send_segments(make_pair(0, 0, 0, 5, 0, 7, 0, 9));
      send_segments(make_pair(0, 0, 4, 0, 1, 2, 3, 2));
      send_segments(make_pair(0, 0, 4, 0, 6, 2, 9, 2));
      send_segments(make_pair(0, 0, 4, 0, 9, 2, 6, 2));
      send_segments(make_pair(0, 0, 4, 4, 4, 0, 0, 4));
      send_segments(make_pair(0, 0, 4, 0, 2, 0, 2, 5));
      send_segments(make_pair(0, 0, 4, 0, 2, 1, 3, 5));
      send_segments(make_pair(0, 0, 4, 0, 7, 1, 9, 3));
      send_segments(make_pair(0, 0, 2, 0, 5, 5, 5, 5));
      send_segments(make_pair(2047, -2048, -2048, 2047, 2047, 2047, -2048, -2048));
      send_segments(make_pair(-2048, 2047, -2048, -2048, 2047, -2048, 2047, 2047));

      for (int i = 0; i < 550; i++) begin
         if (i == 180) begin
            send_idle_pct = 59;
            recv_idle_pct = 17;
         end else if (i == 370) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_segments(rand_pair());
      end
      push <= 1'b0;
      sending_done = 1'b1;

      while (board.pending_dist.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending_dist.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
